FILE: design/fcm_pkg.sv
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared widths, types, opcodes and status codes of the allocation table
// chain manager.
// ----------------------------------------------------------------------------
package fcm_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ENTRY_WIDTH = 16;

	localparam int IDX_W      = $clog2(TABLE_DEPTH);
	localparam int SEC_W      = 16;
	localparam int CNT_W      = 13;
	localparam int OP_W       = 3;
	localparam int ST_W       = 2;
	localparam int LIM_W      = 13;
	localparam int DS_W       = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam int CUR_W      = (ENTRY_WIDTH > SEC_W) ? ENTRY_WIDTH : SEC_W;
	localparam int CMP_W      = CUR_W + 1;
	localparam int STEP_W     = $clog2(TABLE_DEPTH + 2);

	typedef logic [ENTRY_WIDTH-1:0] entry_t;
	typedef logic [SEC_W-1:0]       sector_t;
	typedef logic [CNT_W-1:0]       count_t;
	typedef logic [OP_W-1:0]        opcode_t;
	typedef logic [ST_W-1:0]        status_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CUR_W-1:0]       cur_t;
	typedef logic [CMP_W-1:0]       cmp_t;
	typedef logic [STEP_W-1:0]      step_t;
	typedef logic [LIM_W-1:0]       limit_t;
	typedef logic [DS_W-1:0]        dstart_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	localparam entry_t END_MARK  = {ENTRY_WIDTH{1'b1}};
	localparam entry_t FREE_MARK = '0;

	localparam limit_t  LIMIT_RST  = 13'd4096;
	localparam dstart_t DSTART_RST = 12'd64;

	localparam opcode_t OP_ALLOC = 3'd0;
	localparam opcode_t OP_FREE  = 3'd1;
	localparam opcode_t OP_WALK  = 3'd2;
	localparam opcode_t OP_LOAD  = 3'd3;
	localparam opcode_t OP_READ  = 3'd4;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NO_SPACE = 2'd1;
	localparam status_t ST_BROKEN   = 2'd2;
	localparam status_t ST_RANGE    = 2'd3;

	localparam cfg_idx_t REG_SECTOR_LIMIT = 1'd0;
	localparam cfg_idx_t REG_DATA_START   = 1'd1;

endpackage

FILE: design/fcm_if.sv
// ----------------------------------------------------------------------------
// fcm_if
// Request, response and configuration channels of the chain manager.
// ----------------------------------------------------------------------------
interface fcm_req_if;
	logic             valid;
	logic             ready;
	fcm_pkg::opcode_t opcode;
	fcm_pkg::sector_t sector;
	fcm_pkg::count_t  count;
	fcm_pkg::sector_t entry_value;

	modport source (output valid, output opcode, output sector, output count,
		output entry_value, input ready);
	modport sink (input valid, input opcode, input sector, input count,
		input entry_value, output ready);
endinterface

interface fcm_rsp_if;
	logic             valid;
	logic             ready;
	fcm_pkg::status_t status;
	fcm_pkg::sector_t result_sector;

	modport source (output valid, output status, output result_sector, input ready);
	modport sink (input valid, input status, input result_sector, output ready);
endinterface

interface fcm_cfg_if;
	logic               valid;
	logic               ready;
	fcm_pkg::cfg_idx_t  index;
	fcm_pkg::cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/fcm_ram.sv
// ----------------------------------------------------------------------------
// fcm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/fat_chain_manager_core.sv
// ----------------------------------------------------------------------------
// fat_chain_manager_core
// Allocation table chain manager: allocate, free, walk, load and read over
// one table RAM, one transaction at a time.
// ----------------------------------------------------------------------------
// after reset a clearing pass writes all TABLE_DEPTH entries,
// no request is taken during it; config writes are taken at any time
// load and unknown opcodes: S_DISP, S_RESP, output register; read adds S_READ
// allocate: count scan, then link scan, from data_start, one RAM read per cycle
// free: read, then write free, per link; walk: check and read, then follow
// the next request is taken once the result sits in the output register
// ----------------------------------------------------------------------------
module fat_chain_manager_core (
	input  logic      clk,
	input  logic      arst_n,
	fcm_req_if.sink   req,
	fcm_rsp_if.source rsp,
	fcm_cfg_if.sink   cfg
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DISP     = 4'd2;
	localparam logic [3:0] S_READ     = 4'd3;
	localparam logic [3:0] S_ACNT     = 4'd4;
	localparam logic [3:0] S_ALNK     = 4'd5;
	localparam logic [3:0] S_AEND     = 4'd6;
	localparam logic [3:0] S_FREE_RD  = 4'd7;
	localparam logic [3:0] S_FREE_WR  = 4'd8;
	localparam logic [3:0] S_WALK_CHK = 4'd9;
	localparam logic [3:0] S_WALK_DAT = 4'd10;
	localparam logic [3:0] S_RESP     = 4'd11;

	logic [3:0]        state_q;
	fcm_pkg::idx_t     clr_q;
	fcm_pkg::limit_t   limit_q;
	fcm_pkg::dstart_t  dstart_q;
	fcm_pkg::opcode_t  op_q;
	fcm_pkg::sector_t  sec_q;
	fcm_pkg::count_t   cnt_q;
	fcm_pkg::entry_t   val_q;
	fcm_pkg::cmp_t     scan_q;
	logic              rd_vld_s1;
	fcm_pkg::idx_t     addr_s1;
	fcm_pkg::count_t   avail_q;
	fcm_pkg::count_t   got_q;
	fcm_pkg::idx_t     prev_q;
	fcm_pkg::idx_t     first_q;
	fcm_pkg::cur_t     cur_q;
	fcm_pkg::step_t    step_q;
	fcm_pkg::status_t  res_st_q;
	fcm_pkg::sector_t  res_sec_q;
	logic              out_vld_q;
	fcm_pkg::status_t  out_st_q;
	fcm_pkg::sector_t  out_sec_q;

	logic              ram_we;
	fcm_pkg::idx_t     ram_waddr;
	fcm_pkg::entry_t   ram_wdata;
	logic              ram_re;
	fcm_pkg::idx_t     ram_raddr;
	fcm_pkg::entry_t   ram_rdata;

	fcm_pkg::cmp_t     lim_c;
	logic              scan_go;
	logic              rd_free;
	logic              cur_end;
	logic              cur_zero;
	logic              cur_oor;
	logic              sec_oor;
	logic              steps_done;
	logic              free_go;
	logic              walk_go;
	fcm_pkg::entry_t   load_val;

	fcm_ram #(
		.WIDTH(fcm_pkg::ENTRY_WIDTH),
		.DEPTH(fcm_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign lim_c = (fcm_pkg::cmp_t'(limit_q) < fcm_pkg::cmp_t'(fcm_pkg::TABLE_DEPTH)) ?
		fcm_pkg::cmp_t'(limit_q) : fcm_pkg::cmp_t'(fcm_pkg::TABLE_DEPTH);
	assign scan_go    = scan_q < lim_c;
	assign rd_free    = rd_vld_s1 && (ram_rdata == fcm_pkg::FREE_MARK);
	assign cur_end    = cur_q == fcm_pkg::cur_t'(fcm_pkg::END_MARK);
	assign cur_zero   = cur_q == '0;
	assign cur_oor    = fcm_pkg::cmp_t'(cur_q) >= fcm_pkg::cmp_t'(fcm_pkg::TABLE_DEPTH);
	assign sec_oor    = fcm_pkg::cmp_t'(sec_q) >= fcm_pkg::cmp_t'(fcm_pkg::TABLE_DEPTH);
	assign steps_done = step_q == fcm_pkg::step_t'(fcm_pkg::TABLE_DEPTH + 1);
	assign free_go    = !steps_done && !cur_end && !cur_zero && !cur_oor;
	assign walk_go    = (got_q != cnt_q) && !cur_end && !cur_oor;
	assign load_val   = ((val_q == fcm_pkg::FREE_MARK) &&
		(fcm_pkg::cmp_t'(sec_q) < fcm_pkg::cmp_t'(dstart_q))) ? fcm_pkg::END_MARK : val_q;

	assign req.ready         = state_q == S_IDLE;
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = out_vld_q;
	assign rsp.status        = out_st_q;
	assign rsp.result_sector = out_sec_q;

	// table RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q[fcm_pkg::IDX_W-1:0];
		ram_wdata = fcm_pkg::FREE_MARK;
		ram_re    = 1'b0;
		ram_raddr = cur_q[fcm_pkg::IDX_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_DISP: begin
				if (op_q == fcm_pkg::OP_LOAD && !sec_oor) begin
					ram_we    = 1'b1;
					ram_waddr = sec_q[fcm_pkg::IDX_W-1:0];
					ram_wdata = load_val;
				end
				if (op_q == fcm_pkg::OP_READ && !sec_oor) begin
					ram_re    = 1'b1;
					ram_raddr = sec_q[fcm_pkg::IDX_W-1:0];
				end
			end
			S_ACNT: begin
				ram_re    = scan_go;
				ram_raddr = scan_q[fcm_pkg::IDX_W-1:0];
			end
			S_ALNK: begin
				ram_re    = scan_go;
				ram_raddr = scan_q[fcm_pkg::IDX_W-1:0];
				if (rd_free && got_q != '0) begin
					ram_we    = 1'b1;
					ram_waddr = prev_q;
					ram_wdata = fcm_pkg::entry_t'(addr_s1);
				end
			end
			S_AEND: begin
				ram_we    = 1'b1;
				ram_waddr = prev_q;
				ram_wdata = fcm_pkg::END_MARK;
			end
			S_FREE_RD: begin
				ram_re = free_go;
			end
			S_FREE_WR: begin
				ram_we = 1'b1;
			end
			S_WALK_CHK: begin
				ram_re = walk_go;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			limit_q   <= fcm_pkg::LIMIT_RST;
			dstart_q  <= fcm_pkg::DSTART_RST;
			op_q      <= '0;
			sec_q     <= '0;
			cnt_q     <= '0;
			val_q     <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			addr_s1   <= '0;
			avail_q   <= '0;
			got_q     <= '0;
			prev_q    <= '0;
			first_q   <= '0;
			cur_q     <= '0;
			step_q    <= '0;
			res_st_q  <= fcm_pkg::ST_OK;
			res_sec_q <= '0;
			out_vld_q <= 1'b0;
			out_st_q  <= fcm_pkg::ST_OK;
			out_sec_q <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					fcm_pkg::REG_SECTOR_LIMIT: limit_q <= fcm_pkg::limit_t'(cfg.data);
					fcm_pkg::REG_DATA_START:   dstart_q <= fcm_pkg::dstart_t'(cfg.data);
					default: begin
					end
				endcase
			end

			if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == fcm_pkg::idx_t'(fcm_pkg::TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.opcode;
						sec_q   <= req.sector;
						cnt_q   <= req.count;
						val_q   <= fcm_pkg::entry_t'(req.entry_value);
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					res_st_q  <= fcm_pkg::ST_RANGE;
					res_sec_q <= '0;
					state_q   <= S_RESP;
					case (op_q)
						fcm_pkg::OP_ALLOC: begin
							if (cnt_q == '0) begin
								res_st_q  <= fcm_pkg::ST_OK;
								res_sec_q <= fcm_pkg::sector_t'(fcm_pkg::END_MARK);
							end else begin
								scan_q    <= fcm_pkg::cmp_t'(dstart_q);
								rd_vld_s1 <= 1'b0;
								avail_q   <= '0;
								state_q   <= S_ACNT;
							end
						end
						fcm_pkg::OP_FREE: begin
							cur_q   <= fcm_pkg::cur_t'(sec_q);
							step_q  <= '0;
							state_q <= S_FREE_RD;
						end
						fcm_pkg::OP_WALK: begin
							cur_q   <= fcm_pkg::cur_t'(sec_q);
							got_q   <= '0;
							state_q <= S_WALK_CHK;
						end
						fcm_pkg::OP_LOAD: begin
							if (!sec_oor) begin
								res_st_q  <= fcm_pkg::ST_OK;
								res_sec_q <= fcm_pkg::sector_t'(load_val);
							end
						end
						fcm_pkg::OP_READ: begin
							if (!sec_oor) begin
								state_q <= S_READ;
							end
						end
						default: begin
						end
					endcase
				end
				S_READ: begin
					res_st_q  <= fcm_pkg::ST_OK;
					res_sec_q <= fcm_pkg::sector_t'(ram_rdata);
					state_q   <= S_RESP;
				end
				S_ACNT: begin
					rd_vld_s1 <= scan_go;
					addr_s1   <= scan_q[fcm_pkg::IDX_W-1:0];
					if (scan_go) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rd_free) begin
						avail_q <= avail_q + 1'b1;
						// enough free entries seen, start the linking scan
						if (fcm_pkg::count_t'(avail_q + 1'b1) == cnt_q) begin
							scan_q    <= fcm_pkg::cmp_t'(dstart_q);
							rd_vld_s1 <= 1'b0;
							got_q     <= '0;
							state_q   <= S_ALNK;
						end
					end else if (!rd_vld_s1 && !scan_go) begin
						res_st_q  <= fcm_pkg::ST_NO_SPACE;
						res_sec_q <= '0;
						state_q   <= S_RESP;
					end
				end
				S_ALNK: begin
					rd_vld_s1 <= scan_go;
					addr_s1   <= scan_q[fcm_pkg::IDX_W-1:0];
					if (scan_go) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rd_free) begin
						if (got_q == '0) begin
							first_q <= addr_s1;
						end
						prev_q <= addr_s1;
						got_q  <= got_q + 1'b1;
						if (fcm_pkg::count_t'(got_q + 1'b1) == cnt_q) begin
							state_q <= S_AEND;
						end
					end
				end
				S_AEND: begin
					res_st_q  <= fcm_pkg::ST_OK;
					res_sec_q <= fcm_pkg::sector_t'(first_q);
					state_q   <= S_RESP;
				end
				S_FREE_RD: begin
					if (free_go) begin
						state_q <= S_FREE_WR;
					end else begin
						res_st_q  <= (!steps_done && !cur_end && !cur_zero) ?
							fcm_pkg::ST_RANGE : fcm_pkg::ST_OK;
						res_sec_q <= '0;
						state_q   <= S_RESP;
					end
				end
				S_FREE_WR: begin
					cur_q   <= fcm_pkg::cur_t'(ram_rdata);
					step_q  <= step_q + 1'b1;
					state_q <= S_FREE_RD;
				end
				S_WALK_CHK: begin
					if (got_q == cnt_q) begin
						res_st_q  <= fcm_pkg::ST_OK;
						res_sec_q <= fcm_pkg::sector_t'(cur_q);
						state_q   <= S_RESP;
					end else if (cur_end || cur_oor) begin
						res_st_q  <= fcm_pkg::ST_BROKEN;
						res_sec_q <= '0;
						state_q   <= S_RESP;
					end else begin
						state_q <= S_WALK_DAT;
					end
				end
				S_WALK_DAT: begin
					cur_q   <= fcm_pkg::cur_t'(ram_rdata);
					got_q   <= got_q + 1'b1;
					state_q <= S_WALK_CHK;
				end
				S_RESP: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q <= 1'b1;
						out_st_q  <= res_st_q;
						out_sec_q <= res_sec_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// accepted transaction always goes to dispatch
	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_DISP))
		else $error("accepted transaction did not reach dispatch");

	// the RAM never reads and writes the same entry in one cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("table read and write collide on one entry");

	// linking scan stops once the chain is complete
	a_link_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALNK) |-> (got_q < cnt_q))
		else $error("allocation linked more sectors than requested");

	// a waiting result is not overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.result_sector)))
		else $error("pending result changed before it was taken");

endmodule
